[rtl/htb_pkg.sv]
package htb_pkg;

  localparam int MAX_SYMBOLS = 32;
  localparam int WEIGHT_BITS = 16;

  localparam int IN_W       = 16;
  localparam int OUT_ID_W   = 7;
  localparam int OUT_SUM_W  = 22;

  localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
  localparam int IDX_W      = $clog2(MAX_SYMBOLS);
  localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
  localparam int ID_W       = $clog2(NODE_COUNT);
  localparam int NW_W       = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam int CH_W       = IDX_W + 2;

  // heap slot holds the node id and a copy of its weight
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [NW_W-1:0] wt;
  } heap_entry_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    heap_entry_t       wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   left_id;
    logic [ID_W-1:0]   right_id;
    logic [ID_W-1:0]   new_id;
    logic [NW_W-1:0]   sum;
    logic              last;
    logic              dropped;
  } merge_rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLD_RD,
    S_BLD_LD,
    S_SD_L,
    S_SD_R,
    S_SD_C,
    S_M_RD0,
    S_M_RDL,
    S_M_LDL,
    S_PU_CHK,
    S_PU_CMP
  } htb_state_t;

endpackage

[rtl/htb_heap_ram.sv]
module htb_heap_ram
  import htb_pkg::*;
(
  input  logic        clk,
  input  ram_req_t    req,
  output heap_entry_t rd_q
);

  heap_entry_t mem [MAX_SYMBOLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[req.raddr];
  end

endmodule

[rtl/htb_ctrl.sv]
module htb_ctrl
  import htb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IN_W-1:0]  in_weight,
  input  logic             in_final_item,
  output logic             busy,
  output ram_req_t         req,
  input  heap_entry_t      rd_q,
  output merge_rec_t       rec
);

  htb_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  leaf_cnt_r, leaf_cnt_nxt;
  logic [CNT_W-1:0]  size_r, size_nxt;
  logic              ovf_r, ovf_nxt;
  logic              drop_r, drop_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  heap_entry_t       cur_r, cur_nxt;
  heap_entry_t       lch_r, lch_nxt;
  heap_entry_t       a_r, a_nxt;
  heap_entry_t       b_r, b_nxt;
  heap_entry_t       new_r, new_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              build_r, build_nxt;
  logic              second_r, second_nxt;

  logic [CH_W-1:0]   l_w, r_w;
  logic              l_ok, r_ok;
  logic              full;
  logic [CNT_W-1:0]  n_leaves;
  logic              sd_done;
  logic              emit;
  logic              take_l, take_r;
  logic [NW_W-1:0]   best_wt;
  logic [IDX_W-1:0]  parent;

  assign l_w    = {1'b0, pos_r, 1'b1};
  assign r_w    = l_w + CH_W'(1);
  assign l_ok   = l_w < CH_W'(size_r);
  assign r_ok   = r_w < CH_W'(size_r);
  assign full   = leaf_cnt_r == CNT_W'(MAX_SYMBOLS);
  assign n_leaves = full ? leaf_cnt_r : leaf_cnt_r + CNT_W'(1);
  assign parent = (pos_r - IDX_W'(1)) >> 1;
  assign take_l  = lch_r.wt < cur_r.wt;
  assign best_wt = take_l ? lch_r.wt : cur_r.wt;
  assign take_r  = r_ok && (rd_q.wt < best_wt);
  assign busy   = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      leaf_cnt_r <= '0;
      size_r     <= '0;
      ovf_r      <= 1'b0;
      build_r    <= 1'b0;
      second_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      leaf_cnt_r <= leaf_cnt_nxt;
      size_r     <= size_nxt;
      ovf_r      <= ovf_nxt;
      build_r    <= build_nxt;
      second_r   <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drop_r <= drop_nxt;
    i_r    <= i_nxt;
    pos_r  <= pos_nxt;
    cur_r  <= cur_nxt;
    lch_r  <= lch_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    new_r  <= new_nxt;
    id_r   <= id_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    leaf_cnt_nxt = leaf_cnt_r;
    size_nxt     = size_r;
    ovf_nxt      = ovf_r;
    drop_nxt     = drop_r;
    i_nxt        = i_r;
    pos_nxt      = pos_r;
    cur_nxt      = cur_r;
    lch_nxt      = lch_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    new_nxt      = new_r;
    id_nxt       = id_r;
    build_nxt    = build_r;
    second_nxt   = second_r;
    req          = '0;
    sd_done      = 1'b0;
    emit         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!full) begin
            req.we       = 1'b1;
            req.waddr    = leaf_cnt_r[IDX_W-1:0];
            req.wdata.id = ID_W'(leaf_cnt_r);
            req.wdata.wt = NW_W'(in_weight[WEIGHT_BITS-1:0]);
            leaf_cnt_nxt = leaf_cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final_item) begin
            leaf_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
            drop_nxt     = ovf_r | full;
            if (n_leaves > CNT_W'(1)) begin
              size_nxt  = n_leaves;
              i_nxt     = IDX_W'((n_leaves - CNT_W'(1)) >> 1);
              id_nxt    = ID_W'(n_leaves);
              build_nxt = 1'b1;
              state_nxt = S_BLD_RD;
            end
          end
        end
      end
      S_BLD_RD: begin
        req.raddr = i_r;
        state_nxt = S_BLD_LD;
      end
      S_BLD_LD: begin
        cur_nxt   = rd_q;
        pos_nxt   = i_r;
        state_nxt = S_SD_L;
      end
      S_SD_L: begin
        if (!l_ok) begin
          req.we    = 1'b1;
          req.waddr = pos_r;
          req.wdata = cur_r;
          sd_done   = 1'b1;
        end else begin
          req.raddr = l_w[IDX_W-1:0];
          state_nxt = S_SD_R;
        end
      end
      S_SD_R: begin
        req.raddr = r_w[IDX_W-1:0];
        lch_nxt   = rd_q;
        state_nxt = S_SD_C;
      end
      S_SD_C: begin
        // right child read lands now; strict less-than, left child wins a tie with the right
        req.we    = 1'b1;
        req.waddr = pos_r;
        if (take_r) begin
          req.wdata = rd_q;
          pos_nxt   = r_w[IDX_W-1:0];
          state_nxt = S_SD_L;
        end else if (take_l) begin
          req.wdata = lch_r;
          pos_nxt   = l_w[IDX_W-1:0];
          state_nxt = S_SD_L;
        end else begin
          req.wdata = cur_r;
          sd_done   = 1'b1;
        end
      end
      S_M_RD0: begin
        req.raddr = '0;
        state_nxt = S_M_RDL;
      end
      S_M_RDL: begin
        req.raddr = IDX_W'(size_r - CNT_W'(1));
        if (second_r) begin
          b_nxt = rd_q;
        end else begin
          a_nxt = rd_q;
        end
        state_nxt = S_M_LDL;
      end
      S_M_LDL: begin
        cur_nxt   = rd_q;
        size_nxt  = size_r - CNT_W'(1);
        pos_nxt   = '0;
        state_nxt = S_SD_L;
      end
      S_PU_CHK: begin
        if (pos_r == '0) begin
          req.we    = 1'b1;
          req.waddr = pos_r;
          req.wdata = new_r;
          emit      = 1'b1;
        end else begin
          req.raddr = parent;
          state_nxt = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        req.we    = 1'b1;
        req.waddr = pos_r;
        if (new_r.wt < rd_q.wt) begin
          req.wdata = rd_q;
          pos_nxt   = parent;
          state_nxt = S_PU_CHK;
        end else begin
          req.wdata = new_r;
          emit      = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of one sift-down pass
    if (sd_done) begin
      if (build_r) begin
        if (i_r == '0) begin
          build_nxt  = 1'b0;
          second_nxt = 1'b0;
          state_nxt  = S_M_RD0;
        end else begin
          i_nxt     = i_r - IDX_W'(1);
          state_nxt = S_BLD_RD;
        end
      end else if (!second_r) begin
        second_nxt = 1'b1;
        state_nxt  = S_M_RD0;
      end else begin
        second_nxt = 1'b0;
        new_nxt.id = id_r;
        new_nxt.wt = a_r.wt + b_r.wt;
        pos_nxt    = size_r[IDX_W-1:0];
        size_nxt   = size_r + CNT_W'(1);
        state_nxt  = S_PU_CHK;
      end
    end

    if (emit) begin
      if (size_r == CNT_W'(1)) begin
        size_nxt  = '0;
        state_nxt = S_IDLE;
      end else begin
        id_nxt    = id_r + ID_W'(1);
        state_nxt = S_M_RD0;
      end
    end
  end

  always_comb begin
    rec.valid    = emit;
    rec.left_id  = a_r.id;
    rec.right_id = b_r.id;
    rec.new_id   = new_r.id;
    rec.sum      = new_r.wt;
    rec.last     = size_r == CNT_W'(1);
    rec.dropped  = drop_r;
  end

endmodule

[rtl/huffman_tree_builder.sv]
// Huffman tree builder. Weights load one per start pulse while idle, numbered
// as leaves 0 upward; up to 32 are kept and later ones in the set are discarded
// and reported through out_dropped. The weight marked final starts the build:
// busy stays high while a min-heap is built and n-1 merges run, each merge
// producing one record on out_valid for exactly one cycle. The receiver cannot
// hold records off, so it must take every strobe. All heap traffic goes through
// a heap memory with one write and one registered read port: a sift-down level
// steps through S_SD_L, S_SD_R and S_SD_C, a sift-up level through S_PU_CHK and
// S_PU_CMP.
module huffman_tree_builder
  import htb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [IN_W-1:0]      in_weight,
  input  logic                 in_final_item,
  output logic                 out_valid,
  output logic [OUT_ID_W-1:0]  out_left_node,
  output logic [OUT_ID_W-1:0]  out_right_node,
  output logic [OUT_ID_W-1:0]  out_new_node,
  output logic [OUT_SUM_W-1:0] out_merged_weight,
  output logic                 out_last_merge,
  output logic                 out_dropped
);

  ram_req_t    req;
  heap_entry_t rd_q;
  merge_rec_t  rec;

  logic                 out_valid_r;
  logic [OUT_ID_W-1:0]  left_r, right_r, new_r;
  logic [OUT_SUM_W-1:0] sum_r;
  logic                 last_r, drop_r;

  htb_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_weight     (in_weight),
    .in_final_item (in_final_item),
    .busy          (busy),
    .req           (req),
    .rd_q          (rd_q),
    .rec           (rec)
  );

  htb_heap_ram u_ram (
    .clk  (clk),
    .req  (req),
    .rd_q (rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec.valid) begin
      left_r  <= {{(OUT_ID_W-ID_W){1'b0}}, rec.left_id};
      right_r <= {{(OUT_ID_W-ID_W){1'b0}}, rec.right_id};
      new_r   <= {{(OUT_ID_W-ID_W){1'b0}}, rec.new_id};
      sum_r   <= {{(OUT_SUM_W-NW_W){1'b0}}, rec.sum};
      last_r  <= rec.last;
      drop_r  <= rec.dropped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_node     = left_r;
  assign out_right_node    = right_r;
  assign out_new_node      = new_r;
  assign out_merged_weight = sum_r;
  assign out_last_merge    = last_r;
  assign out_dropped       = drop_r;

endmodule

[tb/huffman_tree_builder_tb.sv]
module huffman_tree_builder_tb
  import htb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 30000;
  localparam int ITEM_TARGET = 370;

  typedef enum int {
    W_FULL,
    W_TIES,
    W_MAX,
    W_EXTREME
  } weight_mix_t;

  typedef struct {
    logic [IN_W-1:0] weight;
    logic            final_item;
    logic            drain_first;
    logic            no_gaps;
  } leaf_item_t;

  typedef struct packed {
    logic [OUT_ID_W-1:0]  left_node;
    logic [OUT_ID_W-1:0]  right_node;
    logic [OUT_ID_W-1:0]  new_node;
    logic [OUT_SUM_W-1:0] merged_weight;
    logic                 last_merge;
    logic                 dropped;
  } merge_rec_exp_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [IN_W-1:0]      in_weight = '0;
  logic                 in_final_item = 1'b0;
  logic                 out_valid;
  logic [OUT_ID_W-1:0]  out_left_node;
  logic [OUT_ID_W-1:0]  out_right_node;
  logic [OUT_ID_W-1:0]  out_new_node;
  logic [OUT_SUM_W-1:0] out_merged_weight;
  logic                 out_last_merge;
  logic                 out_dropped;

  leaf_item_t     leaves_to_send[$];
  merge_rec_exp_t expected_merges[$];
  leaf_item_t     next_leaf;
  int             leaves_taken = 0;
  int             mismatches = 0;
  int             stall_cycles = 0;

  // predictor state
  logic [31:0] node_wt [NODE_COUNT];
  int          heap_ids [MAX_SYMBOLS];
  int          leaves_loaded = 0;
  int          heap_len = 0;
  logic        spilled = 1'b0;

  huffman_tree_builder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_weight         (in_weight),
    .in_final_item     (in_final_item),
    .out_valid         (out_valid),
    .out_left_node     (out_left_node),
    .out_right_node    (out_right_node),
    .out_new_node      (out_new_node),
    .out_merged_weight (out_merged_weight),
    .out_last_merge    (out_last_merge),
    .out_dropped       (out_dropped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void sift_down(int pos);
    int l, r, best, t;
    while (1) begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      best = pos;
      if (l < heap_len && node_wt[heap_ids[l]] < node_wt[heap_ids[pos]]) best = l;
      if (r < heap_len && node_wt[heap_ids[r]] < node_wt[heap_ids[best]]) best = r;
      if (best == pos) return;
      t = heap_ids[best];
      heap_ids[best] = heap_ids[pos];
      heap_ids[pos] = t;
      pos = best;
    end
  endfunction

  function automatic int pop_min();
    int top;
    top = heap_ids[0];
    heap_ids[0] = heap_ids[heap_len - 1];
    heap_len--;
    sift_down(0);
    return top;
  endfunction

  function automatic void push_node(int id);
    int pos;
    pos = heap_len;
    heap_len++;
    while (pos > 0 && node_wt[id] < node_wt[heap_ids[(pos - 1) / 2]]) begin
      heap_ids[pos] = heap_ids[(pos - 1) / 2];
      pos = (pos - 1) / 2;
    end
    heap_ids[pos] = id;
  endfunction

  // load one leaf; on the final one, build the tree and queue every merge record
  function automatic void load_leaf(logic [IN_W-1:0] w, logic fin);
    int n, a, b, nid;
    logic [31:0] total;
    merge_rec_exp_t rec;
    if (leaves_loaded < MAX_SYMBOLS) begin
      node_wt[leaves_loaded] = 32'(w[WEIGHT_BITS-1:0]);
      leaves_loaded++;
    end else begin
      spilled = 1'b1;
    end
    if (!fin) return;
    n = leaves_loaded;
    for (int k = 0; k < n; k++) heap_ids[k] = k;
    heap_len = n;
    if (n > 1) begin
      for (int i = (n - 1) / 2; i >= 0; i--) sift_down(i);
      for (int k = 0; k + 1 < n; k++) begin
        a = pop_min();
        b = pop_min();
        nid = n + k;
        total = node_wt[a] + node_wt[b];
        node_wt[nid] = total;
        push_node(nid);
        rec.left_node = OUT_ID_W'(a);
        rec.right_node = OUT_ID_W'(b);
        rec.new_node = OUT_ID_W'(nid);
        rec.merged_weight = total[OUT_SUM_W-1:0];
        rec.last_merge = (k + 2 == n);
        rec.dropped = spilled;
        expected_merges.push_back(rec);
      end
    end
    leaves_loaded = 0;
    heap_len = 0;
    spilled = 1'b0;
  endfunction

  function automatic void queue_leaf(logic [IN_W-1:0] w, logic fin, logic drain);
    leaf_item_t it;
    it.weight = w;
    it.final_item = fin;
    it.drain_first = drain;
    // a long run of back-to-back transactions in the middle of the stream
    it.no_gaps = (leaves_to_send.size() >= 150 && leaves_to_send.size() < 240);
    leaves_to_send.push_back(it);
  endfunction

  function automatic void queue_set(int n, weight_mix_t mix, logic drain);
    logic [IN_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      case (mix)
        W_FULL:  w = IN_W'($urandom);
        W_TIES:  w = IN_W'($urandom_range(3));
        W_MAX:   w = '1;
        default: begin
          case ($urandom_range(2))
            0:       w = '0;
            1:       w = '1;
            default: w = IN_W'($urandom);
          endcase
        end
      endcase
      queue_leaf(w, i == n - 1, drain && i == 0);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        load_leaf(in_weight, in_final_item);
        leaves_taken++;
      end
      if (!start || !busy) begin
        if (leaves_to_send.size() != 0 &&
            !(leaves_to_send[0].drain_first && expected_merges.size() != 0) &&
            (leaves_to_send[0].no_gaps || $urandom_range(99) >= 29)) begin
          next_leaf = leaves_to_send.pop_front();
          start <= 1'b1;
          in_weight <= next_leaf.weight;
          in_final_item <= next_leaf.final_item;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    merge_rec_exp_t got, want;
    if (rst_n && out_valid) begin
      got.left_node = out_left_node;
      got.right_node = out_right_node;
      got.new_node = out_new_node;
      got.merged_weight = out_merged_weight;
      got.last_merge = out_last_merge;
      got.dropped = out_dropped;
      if (expected_merges.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected merge record l=%0d r=%0d n=%0d w=%0d last=%0b drop=%0b",
                 $time, got.left_node, got.right_node, got.new_node, got.merged_weight,
                 got.last_merge, got.dropped);
      end else begin
        want = expected_merges.pop_front();
        if (got != want) begin
          mismatches++;
          $display("%0t: merge mismatch exp l=%0d r=%0d n=%0d w=%0d last=%0b drop=%0b",
                   $time, want.left_node, want.right_node, want.new_node,
                   want.merged_weight, want.last_merge, want.dropped);
          $display("%0t:                act l=%0d r=%0d n=%0d w=%0d last=%0b drop=%0b",
                   $time, got.left_node, got.right_node, got.new_node,
                   got.merged_weight, got.last_merge, got.dropped);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n, r, total_leaves;
    weight_mix_t mix;

    // directed: single leaf, extremes, ties, descending and ascending weights
    queue_leaf('0, 1'b1, 1'b0);
    queue_leaf('0, 1'b0, 1'b0);
    queue_leaf('1, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) queue_leaf(16'd7, i == 3, 1'b0);
    queue_leaf(16'd300, 1'b0, 1'b0);
    queue_leaf(16'd200, 1'b0, 1'b0);
    queue_leaf(16'd100, 1'b1, 1'b0);
    for (int i = 1; i <= 5; i++) queue_leaf(IN_W'(i), i == 5, 1'b0);

    // full set of max weights plus spill, final arrives with no room left;
    // sender holds off until every earlier record is out
    queue_set(MAX_SYMBOLS + 2, W_MAX, 1'b1);

    while (leaves_to_send.size() < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 8) n = 1;
      else if (r < 65) n = $urandom_range(10, 2);
      else if (r < 85) n = $urandom_range(MAX_SYMBOLS - 1, 11);
      else n = $urandom_range(MAX_SYMBOLS + 3, MAX_SYMBOLS);
      r = $urandom_range(99);
      if (r < 55) mix = W_FULL;
      else if (r < 80) mix = W_TIES;
      else if (r < 88) mix = W_MAX;
      else mix = W_EXTREME;
      queue_set(n, mix, $urandom_range(9) == 0);
    end
    total_leaves = leaves_to_send.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (leaves_taken < total_leaves) @(posedge clk);
    while (expected_merges.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatches == 0 && expected_merges.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/htb_pkg.sv
rtl/htb_heap_ram.sv
rtl/htb_ctrl.sv
rtl/huffman_tree_builder.sv
tb/huffman_tree_builder_tb.sv
